[design/alidf_pkg.sv]
`default_nettype none

package alidf_pkg;

    // default list depth
    localparam int CAPACITY_DEF = 64;

    // operation codes
    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_DELETE = 2'd1;
    localparam logic [1:0] OP_FIND   = 2'd2;

    // status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_EMPTY     = 2'd2;
    localparam logic [1:0] ST_NOT_FOUND = 2'd3;

    // request word
    typedef struct packed {
        logic [1:0]         operation;
        logic [6:0]         position;
        logic signed [31:0] item_value;
    } t_in_item;

    // result word
    typedef struct packed {
        logic [1:0] status;
        logic [5:0] found_index;
        logic [6:0] entry_count;
    } t_out_item;

    // controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_INIT,
        S_LOOP,
        S_RD,
        S_MOVE,
        S_CHK,
        S_PUT,
        S_RESULT
    } t_state;

    // commands from controller to datapath
    typedef struct packed {
        logic       load;
        logic       init_idx;
        logic       rd;
        logic       move;
        logic       step;
        logic       put;
        logic       cnt_inc;
        logic       cnt_dec;
        logic       set_status;
        logic [1:0] status;
        logic       set_found;
        logic       out_load;
    } t_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic [1:0] op;
        logic       full;
        logic       empty;
        logic       loop_done;
        logic       match;
        logic       out_free;
    } t_sts;

endpackage

`default_nettype wire

[design/array_list_insert_delete_find.sv]
// insert walks init, then a loop/read/move step per entry shifted up, then put and result;
//   delete walks init, a loop/read/move step per entry shifted down, then result; find walks
//   init, a loop/read/check step per entry compared, ending at the first hit or past the count;
//   insert into a full list, delete from an empty list and the unused code skip to result
// a new word is taken only once the previous result is registered; an output stall holds it back
// reset clears the count, controller state and output valid; entry store is not cleared
`default_nettype none

module array_list_insert_delete_find
    import alidf_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_stall,
    input  wire t_in_item i_in_item,
    output logic          o_out_valid,
    input  wire logic     i_out_stall,
    output t_out_item     o_out_item
);

    t_cmd cmd;
    t_sts sts;

    // sequencer
    alidf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    // store, count and result register
    alidf_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_item   (i_in_item),
        .i_out_stall (i_out_stall),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item)
    );

endmodule

`default_nettype wire

[design/alidf_ctrl.sv]
`default_nettype none

module alidf_ctrl
    import alidf_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    input  wire t_sts i_sts,
    output t_cmd      o_cmd,
    output logic      o_in_stall
);

    t_state r_state;
    t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_INIT;
                end
            end
            S_INIT: n_state = S_LOOP;
            S_LOOP: begin
                case (i_sts.op)
                    OP_INSERT: begin
                        if (i_sts.full) begin
                            n_state = S_RESULT;
                        end else if (i_sts.loop_done) begin
                            n_state = S_PUT;
                        end else begin
                            n_state = S_RD;
                        end
                    end
                    OP_DELETE: begin
                        if (i_sts.empty || i_sts.loop_done) begin
                            n_state = S_RESULT;
                        end else begin
                            n_state = S_RD;
                        end
                    end
                    OP_FIND: begin
                        if (i_sts.loop_done) begin
                            n_state = S_RESULT;
                        end else begin
                            n_state = S_RD;
                        end
                    end
                    default: n_state = S_RESULT;
                endcase
            end
            S_RD: begin
                if (i_sts.op == OP_FIND) begin
                    n_state = S_CHK;
                end else begin
                    n_state = S_MOVE;
                end
            end
            S_MOVE: n_state = S_LOOP;
            S_CHK: begin
                if (i_sts.match) begin
                    n_state = S_RESULT;
                end else begin
                    n_state = S_LOOP;
                end
            end
            S_PUT: n_state = S_RESULT;
            S_RESULT: begin
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // command outputs
    always_comb begin
        o_cmd      = '0;
        o_in_stall = (r_state != S_IDLE);
        case (r_state)
            S_IDLE: o_cmd.load = i_in_valid;
            S_INIT: o_cmd.init_idx = 1'b1;
            S_LOOP: begin
                case (i_sts.op)
                    OP_INSERT: begin
                        if (i_sts.full) begin
                            o_cmd.set_status = 1'b1;
                            o_cmd.status     = ST_FULL;
                        end
                    end
                    OP_DELETE: begin
                        if (i_sts.empty) begin
                            o_cmd.set_status = 1'b1;
                            o_cmd.status     = ST_EMPTY;
                        end else if (i_sts.loop_done) begin
                            o_cmd.cnt_dec = 1'b1;
                        end
                    end
                    OP_FIND: begin
                        if (i_sts.loop_done) begin
                            o_cmd.set_status = 1'b1;
                            o_cmd.status     = ST_NOT_FOUND;
                        end
                    end
                    default: o_cmd.status = ST_OK;
                endcase
            end
            S_RD: o_cmd.rd = 1'b1;
            S_MOVE: begin
                o_cmd.move = 1'b1;
                o_cmd.step = 1'b1;
            end
            S_CHK: begin
                o_cmd.set_found = i_sts.match;
                o_cmd.step      = !i_sts.match;
            end
            S_PUT: begin
                o_cmd.put     = 1'b1;
                o_cmd.cnt_inc = 1'b1;
            end
            S_RESULT: o_cmd.out_load = i_sts.out_free;
            default: o_cmd = '0;
        endcase
    end

endmodule

`default_nettype wire

[design/alidf_dp.sv]
`default_nettype none

module alidf_dp
    import alidf_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_in_item i_in_item,
    input  wire logic     i_out_stall,
    input  wire t_cmd     i_cmd,
    output t_sts          o_sts,
    output logic          o_out_valid,
    output t_out_item     o_out_item
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = $clog2(CAPACITY);
    localparam int XW = CW + 7;

    logic [31:0]   mem [CAPACITY];
    logic [31:0]   r_rdata;
    logic [1:0]    r_op;
    logic [31:0]   r_value;
    logic [CW-1:0] r_pos;
    logic [CW-1:0] r_idx;
    logic [CW-1:0] r_count;
    logic [1:0]    r_status;
    logic [CW-1:0] r_found;
    logic          r_out_valid;
    t_out_item     r_out_item;

    logic [XW-1:0] pos_x;
    logic [XW-1:0] cnt_x;
    logic [CW-1:0] pos_c;
    logic [CW-1:0] rd_idx;
    logic [CW:0]   idx_p1;
    logic          out_free;

    // clamp the requested position against the current count
    always_comb begin
        pos_x = XW'(i_in_item.position);
        cnt_x = XW'(r_count);
        pos_c = CW'(i_in_item.position);
        case (i_in_item.operation)
            OP_INSERT: begin
                if (pos_x > cnt_x) begin
                    pos_c = r_count;
                end
            end
            OP_DELETE: begin
                if (r_count == '0) begin
                    pos_c = '0;
                end else if (pos_x > cnt_x - 1'b1) begin
                    pos_c = r_count - 1'b1;
                end
            end
            default: pos_c = '0;
        endcase
    end

    // source address: below for insert, above for delete, current for find
    always_comb begin
        case (r_op)
            OP_INSERT: rd_idx = r_idx - 1'b1;
            OP_DELETE: rd_idx = r_idx + 1'b1;
            default:   rd_idx = r_idx;
        endcase
    end

    assign idx_p1   = {1'b0, r_idx} + 1'b1;
    assign out_free = !r_out_valid || !i_out_stall;

    // status back to the controller
    always_comb begin
        o_sts.op       = r_op;
        o_sts.full     = (r_count == CW'(CAPACITY));
        o_sts.empty    = (r_count == '0);
        o_sts.match    = (r_rdata == r_value);
        o_sts.out_free = out_free;
        case (r_op)
            OP_INSERT: o_sts.loop_done = (r_idx == r_pos);
            OP_DELETE: o_sts.loop_done = (idx_p1 >= {1'b0, r_count});
            default:   o_sts.loop_done = (r_idx >= r_count);
        endcase
    end

    // entry store, one write and one registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.move) begin
            mem[r_idx[IW-1:0]] <= r_rdata;
        end else if (i_cmd.put) begin
            mem[r_idx[IW-1:0]] <= r_value;
        end
        if (i_cmd.rd) begin
            r_rdata <= mem[rd_idx[IW-1:0]];
        end
    end

    // request and loop registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op     <= i_in_item.operation;
            r_value  <= i_in_item.item_value;
            r_pos    <= pos_c;
            r_status <= ST_OK;
            r_found  <= '0;
        end
        if (i_cmd.init_idx) begin
            case (r_op)
                OP_INSERT: r_idx <= r_count;
                OP_DELETE: r_idx <= r_pos;
                default:   r_idx <= '0;
            endcase
        end else if (i_cmd.step) begin
            if (r_op == OP_INSERT) begin
                r_idx <= r_idx - 1'b1;
            end else begin
                r_idx <= r_idx + 1'b1;
            end
        end
        if (i_cmd.set_status) begin
            r_status <= i_cmd.status;
        end
        if (i_cmd.set_found) begin
            r_found <= r_idx;
        end
    end

    // entry count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.cnt_inc) begin
            r_count <= r_count + 1'b1;
        end else if (i_cmd.cnt_dec) begin
            r_count <= r_count - 1'b1;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
        if (i_cmd.out_load) begin
            r_out_item.status      <= r_status;
            r_out_item.found_index <= 6'(r_found);
            r_out_item.entry_count <= 7'(r_count);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // checks
    a_cnt_inc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.cnt_inc |=> r_count == $past(r_count) + 1'b1)
        else $error("count did not advance on insert");

    a_put_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.put |-> (r_idx == r_pos) && (r_op == OP_INSERT))
        else $error("insert written away from its position");

    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> out_free)
        else $error("result overwrote a held word");

    a_cnt_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.cnt_inc |-> r_count < CW'(CAPACITY))
        else $error("insert into a full list");

endmodule

`default_nettype wire
